FILE: sv/wfs_pkg.sv
// Package for the wire field serialiser: operation codes and the packed
// transaction types of the request and response channels. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wfs_pkg;

  localparam logic [3:0] OP_I8       = 4'd0;
  localparam logic [3:0] OP_I16      = 4'd1;
  localparam logic [3:0] OP_I32      = 4'd2;
  localparam logic [3:0] OP_I64      = 4'd3;
  localparam logic [3:0] OP_SVARINT  = 4'd4;
  localparam logic [3:0] OP_UVARINT  = 4'd5;
  localparam logic [3:0] OP_ARRLEN   = 4'd6;
  localparam logic [3:0] OP_BYTES    = 4'd7;
  localparam logic [3:0] OP_VARBYTES = 4'd8;
  localparam logic [3:0] OP_STR      = 4'd9;
  localparam logic [3:0] OP_NULLSTR  = 4'd10;
  localparam logic [3:0] OP_NULLARR  = 4'd11;
  localparam logic [3:0] OP_TAGS     = 4'd12;
  localparam logic [3:0] OP_RAW      = 4'd13;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [63:0] value;
    logic [30:0]        length;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } rsp_t;

endpackage

`default_nettype wire

FILE: sv/wire_field_serializer.sv
// Top level of the wire field serialiser: one shift register and a small
// sequencer emit the encoded bytes of a field. Depends on wfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A request transaction (operation, value, length) is accepted when
// req_valid is high and req_stall is low. The block then emits the field's
// wire bytes as response transactions on rsp, one byte per cycle while the
// receiver does not stall, with last set on the final byte. Fixed-width
// integers go out most significant byte first; varints go out as LEB128
// groups, least significant first.
// On acceptance the field is loaded into the shared shift register, and the
// output byte register is loaded from it. An item of N bytes (one to ten)
// occupies the shift register until all its bytes are out; req_stall is
// high until the last byte has been loaded into the output register, so a
// new request may be taken while that final byte still waits. Requests
// that produce no bytes (unused codes, tagged fields in fixed mode) are
// taken without leaving the idle state.
// When the receiver raises rsp_stall, the output register holds its byte
// and the shifter pauses. The mode register is written with cfg_write and
// cfg_data; the user must write it only while idle, unchecked by the block.
// Synchronous reset clears the mode to fixed format and empties the block.
module wire_field_serializer import wfs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire logic cfg_data,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic        state;
  logic        flexible_mode;
  logic [63:0] work;
  logic        is_var;
  logic [3:0]  count;

  logic [63:0] word_next;
  logic        is_var_next;
  logic        none_next;
  logic [3:0]  count_next;
  logic [31:0] len32;
  logic [31:0] len_inc;
  logic [63:0] zig;
  logic [7:0]  byte_next;
  logic        last_next;
  logic        advance;

  assign len32   = {1'b0, req.length};
  assign len_inc = len32 + 32'd1;
  assign zig     = {req.value[62:0], 1'b0} ^ {64{req.value[63]}};

  always_comb begin
    word_next   = '0;
    is_var_next = 1'b0;
    none_next   = 1'b0;
    count_next  = 4'd1;
    case (req.operation)
      OP_I8: begin
        word_next = {req.value[7:0], 56'd0};
      end
      OP_I16: begin
        word_next  = {req.value[15:0], 48'd0};
        count_next = 4'd2;
      end
      OP_I32: begin
        word_next  = {req.value[31:0], 32'd0};
        count_next = 4'd4;
      end
      OP_I64: begin
        word_next  = req.value;
        count_next = 4'd8;
      end
      OP_SVARINT: begin
        word_next   = zig;
        is_var_next = 1'b1;
      end
      OP_UVARINT: begin
        word_next   = req.value;
        is_var_next = 1'b1;
      end
      OP_ARRLEN, OP_BYTES: begin
        if (flexible_mode) begin
          word_next   = {32'd0, len_inc};
          is_var_next = 1'b1;
        end else begin
          word_next  = (req.operation == OP_BYTES && len32 == 32'd0) ?
                       {32'hFFFF_FFFF, 32'd0} : {len32, 32'd0};
          count_next = 4'd4;
        end
      end
      OP_VARBYTES: begin
        word_next   = (len32 == 32'd0) ? 64'd1 : {32'd0, req.length, 1'b0};
        is_var_next = 1'b1;
      end
      OP_STR, OP_NULLSTR: begin
        if (req.operation == OP_NULLSTR && len32 == 32'd0) begin
          if (flexible_mode) begin
            word_next   = '0;
            is_var_next = 1'b1;
          end else begin
            word_next  = {16'hFFFF, 48'd0};
            count_next = 4'd2;
          end
        end else if (flexible_mode) begin
          word_next   = {32'd0, len_inc};
          is_var_next = 1'b1;
        end else begin
          word_next  = {len32[15:0], 48'd0};
          count_next = 4'd2;
        end
      end
      OP_NULLARR: begin
        if (len32 == 32'd0) begin
          if (flexible_mode) begin
            word_next   = '0;
            is_var_next = 1'b1;
          end else begin
            word_next  = {32'hFFFF_FFFF, 32'd0};
            count_next = 4'd4;
          end
        end else if (flexible_mode) begin
          word_next   = {32'd0, len_inc};
          is_var_next = 1'b1;
        end else begin
          word_next  = {len32, 32'd0};
          count_next = 4'd4;
        end
      end
      OP_TAGS: begin
        word_next   = '0;
        is_var_next = 1'b1;
        none_next   = !flexible_mode;
      end
      OP_RAW: begin
        word_next = {req.value[7:0], 56'd0};
      end
      default: begin
        none_next = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (is_var) begin
      last_next = (work[63:7] == 57'd0);
      byte_next = {!last_next, work[6:0]};
    end else begin
      last_next = (count == 4'd1);
      byte_next = work[63:56];
    end
  end

  assign req_stall = (state != ST_IDLE);
  assign advance   = (state == ST_EMIT) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      flexible_mode <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        flexible_mode <= cfg_data;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid && !none_next) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (advance && last_next) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      work   <= word_next;
      is_var <= is_var_next;
      count  <= count_next;
    end else if (advance) begin
      rsp.out_byte <= byte_next;
      rsp.last     <= last_next;
      count        <= count - 4'd1;
      work         <= is_var ? {7'd0, work[63:7]} : {work[55:0], 8'd0};
    end
  end

endmodule

`default_nettype wire
